/* rtl/tmcg_pkg.sv */
// Package for the text-mode character generator.
// Holds the transaction payload types, operation and layout codes and memory constants.
// No dependencies.
`default_nettype none

package tmcg_pkg;

    localparam int unsigned MEM_AW    = 11;
    localparam int unsigned MEM_DEPTH = 2048;
    localparam int unsigned BYTE_W    = 8;

    localparam logic [1:0] OP_TEXT_WR = 2'd0;
    localparam logic [1:0] OP_FONT_WR = 2'd1;
    localparam logic [1:0] OP_PIXEL   = 2'd2;

    localparam logic LAYOUT_ROW_MAJOR  = 1'b0;
    localparam logic LAYOUT_CODE_MAJOR = 1'b1;

    typedef struct packed {
        logic [1:0]        op;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        data;
    } t_in;

    typedef struct packed {
        logic       pixel;
        logic [8:0] pixel_x;
        logic [7:0] pixel_y;
        logic       frame_end;
    } t_out;

    typedef struct packed {
        logic [2:0] bit_idx;
        logic [8:0] x;
        logic [7:0] y;
        logic       last;
    } t_tag;

endpackage

`default_nettype wire

/* rtl/tmcg_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
// A read and a write to the same entry in one cycle return the old contents.
// No dependencies.
`default_nettype none

module tmcg_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/text_mode_character_generator_top.sv */
// Top level of the text-mode character generator: raster counters, text and
// font memories and a three-stage pixel pipeline with an output register.
// Depends on tmcg_pkg and tmcg_ram.
//
//  Channel   Direction  Handshake            Payload
//  input     in         i_valid / o_stall    i_in  (tmcg_pkg::t_in)
//  output    out        o_valid / i_stall    o_out (tmcg_pkg::t_out)
//  config    in         APB psel/penable     pwdata[0] = layout_mode
//
// One transaction is accepted per clock cycle when the output side keeps up.
// o_valid rises for a pixel once it has passed the stages in order: the text memory is read
// at the accepting edge, then the font memory, and then the output register is loaded.
// Writes finish in the cycle they are accepted and produce no output.
// Reset clears the raster position, layout mode and pipeline valids only.
// The input is stalled only while all three stages hold pixels and the output is stalled.
`default_nettype none

module text_mode_character_generator_top #(
    parameter int unsigned TEXT_COLS     = 64,
    parameter int unsigned MAX_TEXT_ROWS = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire tmcg_pkg::t_in i_in,
    output logic               o_valid,
    input  wire logic          i_stall,
    output tmcg_pkg::t_out     o_out,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [1:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready
);

    localparam int unsigned WIDTH     = TEXT_COLS * 8;
    localparam int unsigned LINES_MAX = MAX_TEXT_ROWS * 8;
    localparam int unsigned LINES_MIN = (MAX_TEXT_ROWS / 2) * 8;
    localparam int unsigned COL_W     = $clog2(WIDTH);
    localparam int unsigned LINE_W    = $clog2(LINES_MAX);

    logic              r_mode;
    logic [COL_W-1:0]  r_col;
    logic [LINE_W-1:0] r_line;
    logic [COL_W-1:0]  n_col;
    logic [LINE_W-1:0] n_line;

    logic              r_a_v;
    logic [2:0]        r_a_row;
    tmcg_pkg::t_tag    r_a_tag;
    logic              r_b_v;
    logic              r_b_inv;
    tmcg_pkg::t_tag    r_b_tag;
    logic              r_o_v;
    tmcg_pkg::t_out    r_o;

    logic              o_free;
    logic              b_free;
    logic              a_free;
    logic              in_acc;
    logic              pix_acc;
    logic              cfg_wr;

    logic [31:0]       lines;
    logic              restart;
    logic [COL_W-1:0]  cur_col;
    logic [LINE_W-1:0] cur_line;
    logic              last_col;
    logic              last_line;
    logic [31:0]       text_lin;
    logic [tmcg_pkg::MEM_AW-1:0] text_raddr;
    logic [tmcg_pkg::MEM_AW-1:0] font_raddr;
    logic [7:0]        code;
    logic [7:0]        glyph;
    tmcg_pkg::t_tag    a_tag;

    // Configuration port.
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {31'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= tmcg_pkg::LAYOUT_ROW_MAJOR;
        end else if (cfg_wr) begin
            r_mode <= pwdata[0];
        end
    end

    // Pipeline flow control.
    assign o_free  = !r_o_v || !i_stall;
    assign b_free  = !r_b_v || o_free;
    assign a_free  = !r_a_v || b_free;
    assign o_stall = !a_free;
    assign in_acc  = i_valid && a_free;
    assign pix_acc = in_acc && (i_in.op == tmcg_pkg::OP_PIXEL);

    // Raster position, with a restart when the layout no longer fits.
    assign lines     = (r_mode == tmcg_pkg::LAYOUT_CODE_MAJOR) ? 32'(LINES_MAX)
                                                               : 32'(LINES_MIN);
    assign restart   = (32'(r_line) >= lines) || (32'(r_col) >= 32'(WIDTH));
    assign cur_col   = restart ? '0 : r_col;
    assign cur_line  = restart ? '0 : r_line;
    assign last_col  = 32'(cur_col) == 32'(WIDTH - 1);
    assign last_line = 32'(cur_line) == (lines - 32'd1);

    always_comb begin
        n_col  = cur_col + COL_W'(1);
        n_line = cur_line;
        if (last_col && last_line) begin
            n_col  = '0;
            n_line = '0;
        end else if (last_col) begin
            n_col  = '0;
            n_line = cur_line + LINE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_line <= '0;
        end else if (pix_acc) begin
            r_col  <= n_col;
            r_line <= n_line;
        end
    end

    // Text memory lookup.
    assign text_lin   = 32'(cur_col >> 3) + 32'(cur_line >> 3) * 32'(TEXT_COLS);
    assign text_raddr = text_lin[tmcg_pkg::MEM_AW-1:0];

    assign a_tag.bit_idx = cur_col[2:0];
    assign a_tag.x       = 9'(cur_col);
    assign a_tag.y       = 8'(cur_line);
    assign a_tag.last    = last_col && last_line;

    tmcg_ram #(
        .WIDTH (tmcg_pkg::BYTE_W),
        .DEPTH (tmcg_pkg::MEM_DEPTH)
    ) u_text_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && (i_in.op == tmcg_pkg::OP_TEXT_WR)),
        .i_waddr (i_in.addr),
        .i_wdata (i_in.data),
        .i_re    (a_free),
        .i_raddr (text_raddr),
        .o_rdata (code)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (a_free) begin
            r_a_v <= pix_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_free) begin
            r_a_row <= cur_line[2:0];
            r_a_tag <= a_tag;
        end
    end

    // Font memory lookup.
    always_comb begin
        if (r_mode == tmcg_pkg::LAYOUT_CODE_MAJOR) begin
            font_raddr = {code, r_a_row};
        end else begin
            font_raddr = {1'b0, r_a_row, code[6:0]};
        end
    end

    tmcg_ram #(
        .WIDTH (tmcg_pkg::BYTE_W),
        .DEPTH (tmcg_pkg::MEM_DEPTH)
    ) u_font_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && (i_in.op == tmcg_pkg::OP_FONT_WR)),
        .i_waddr (i_in.addr),
        .i_wdata (i_in.data),
        .i_re    (b_free),
        .i_raddr (font_raddr),
        .o_rdata (glyph)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (b_free) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_free) begin
            r_b_inv <= code[7] && (r_mode == tmcg_pkg::LAYOUT_ROW_MAJOR);
            r_b_tag <= r_a_tag;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (o_free) begin
            r_o_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free) begin
            r_o.pixel     <= glyph[3'd7 - r_b_tag.bit_idx] ^ r_b_inv;
            r_o.pixel_x   <= r_b_tag.x;
            r_o.pixel_y   <= r_b_tag.y;
            r_o.frame_end <= r_b_tag.last;
        end
    end

    assign o_valid = r_o_v;
    assign o_out   = r_o;

`ifndef SYNTH
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_a_v && r_b_v && r_o_v))
        else $error("Input stalled while the pipeline has a free stage.");

    a_frame_end_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.frame_end) |-> (o_out.pixel_x == 9'(WIDTH - 1)))
        else $error("Frame end marked away from the last column.");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix_acc |=> (32'(r_col) < 32'(WIDTH)))
        else $error("Raster column left the screen after a pixel.");

    a_write_keeps_raster: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in.op != tmcg_pkg::OP_PIXEL)) |=> ($stable(r_col) && $stable(r_line)))
        else $error("A memory write moved the raster position.");
`endif

endmodule

`default_nettype wire
